[sv/tthcb_pkg.sv]
package tthcb_pkg;

    localparam int CFG_INDEX_W = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_DROP_MARGIN    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADING_OFFSET = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FULL_POWER     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GLIDE_POWER    = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GLIDE_GAIN     = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_GAIN      = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BRAKE_HOLD_MS  = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_MS       = 4'd7;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam logic [1:0] KIND_DRIVE   = 2'd0;
    localparam logic [1:0] KIND_BRAKE   = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;
    localparam logic [1:0] KIND_STARTED = 2'd3;

    localparam logic [1:0] MODE_FULL  = 2'd0;
    localparam logic [1:0] MODE_COAST = 2'd1;
    localparam logic [1:0] MODE_BRAKE = 2'd2;

    localparam logic [15:0] SMALL_ERR_MAX  = 16'd910;
    localparam logic [19:0] SLOW_RATE_MAX  = 20'd45;
    localparam logic [14:0] FULL_POWER_RST = 15'd32767;
    localparam int          GAIN_SHIFT     = 12;

    typedef struct packed {
        logic [14:0]        drop_margin;
        logic signed [15:0] heading_offset;
        logic [14:0]        full_power;
        logic [14:0]        glide_power;
        logic [15:0]        glide_gain;
        logic [15:0]        stop_gain;
        logic [15:0]        brake_hold_ms;
        logic [31:0]        limit_ms;
    } cfg_t;

    typedef struct packed {
        logic               action;
        logic signed [15:0] heading;
        logic signed [15:0] bearing;
        logic signed [19:0] turn_rate;
        logic [31:0]        now_ms;
    } item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] front_left;
        logic signed [15:0] front_right;
        logic signed [15:0] back_left;
        logic signed [15:0] back_right;
    } result_t;

endpackage

[sv/tthcb_item_if.sv]
interface tthcb_item_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [15:0] heading;
    logic signed [15:0] bearing;
    logic signed [19:0] turn_rate;
    logic [31:0]        now_ms;

    modport source (output valid, action, heading, bearing, turn_rate, now_ms, input ready);
    modport sink (input valid, action, heading, bearing, turn_rate, now_ms, output ready);
endinterface

[sv/tthcb_result_if.sv]
interface tthcb_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [15:0] front_left;
    logic signed [15:0] front_right;
    logic signed [15:0] back_left;
    logic signed [15:0] back_right;

    modport source (output valid, kind, front_left, front_right, back_left, back_right,
                    input ready);
    modport sink (input valid, kind, front_left, front_right, back_left, back_right,
                  output ready);
endinterface

[sv/tthcb_cfg_if.sv]
interface tthcb_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tthcb_pkg::CFG_INDEX_W-1:0]  index;
    logic [31:0]                        data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[sv/tthcb_cfg_regs.sv]
module tthcb_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [tthcb_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [31:0]                       wr_data,
    output tthcb_pkg::cfg_t                   cfg
);

    tthcb_pkg::cfg_t cfg_reg;
    tthcb_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                tthcb_pkg::REG_DROP_MARGIN:    cfg_next.drop_margin    = wr_data[14:0];
                tthcb_pkg::REG_HEADING_OFFSET: cfg_next.heading_offset = wr_data[15:0];
                tthcb_pkg::REG_FULL_POWER:     cfg_next.full_power     = wr_data[14:0];
                tthcb_pkg::REG_GLIDE_POWER:    cfg_next.glide_power    = wr_data[14:0];
                tthcb_pkg::REG_GLIDE_GAIN:     cfg_next.glide_gain     = wr_data[15:0];
                tthcb_pkg::REG_STOP_GAIN:      cfg_next.stop_gain      = wr_data[15:0];
                tthcb_pkg::REG_BRAKE_HOLD_MS:  cfg_next.brake_hold_ms  = wr_data[15:0];
                tthcb_pkg::REG_LIMIT_MS:       cfg_next.limit_ms       = wr_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{full_power: tthcb_pkg::FULL_POWER_RST, default: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/tthcb_ctrl.sv]
module tthcb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  tthcb_pkg::item_t  item,
    input  tthcb_pkg::cfg_t   cfg,
    output tthcb_pkg::result_t result
);

    logic [15:0] goal_reg, goal_next;
    logic [15:0] first_error_reg, first_error_next;
    logic [1:0]  mode_reg, mode_next;
    logic        spin_neg_reg, spin_neg_next;
    logic        braking_reg, braking_next;
    logic [31:0] brake_since_reg, brake_since_next;
    logic [31:0] start_time_reg, start_time_next;

    // start path
    logic [15:0] cand_lo, cand_hi, off_lo, off_hi, pick, goal_start, err_start;
    // tick path
    logic [15:0] err, err_mag;
    logic [19:0] rate_abs;
    logic [27:0] err_scaled;
    logic [35:0] glide_prod, stop_prod;
    logic [31:0] run_time, brake_elapsed;
    logic        small_err, sign_flip, timed_out, early_done;
    logic        glide_hit, stop_hit, brake_end;
    logic [1:0]  mode_glide, mode_stop;
    logic [1:0]  kind;
    logic [14:0] power;
    logic        spin_out;
    logic [15:0] drive;

    function automatic logic [15:0] mag16(input logic [15:0] v);
        mag16 = v[15] ? 16'(-v) : v;
    endfunction

    always_comb
    begin
        cand_lo    = 16'(item.bearing - {1'b0, cfg.drop_margin});
        cand_hi    = 16'(item.bearing + {1'b0, cfg.drop_margin});
        off_lo     = 16'(cand_lo - item.heading);
        off_hi     = 16'(cand_hi - item.heading);
        pick       = (mag16(off_lo) < mag16(off_hi)) ? cand_lo : cand_hi;
        goal_start = 16'(pick + cfg.heading_offset);
        err_start  = 16'(goal_start - item.heading);

        err        = 16'(goal_reg - item.heading);
        err_mag    = mag16(err);
        rate_abs   = item.turn_rate[19] ? 20'(-item.turn_rate) : item.turn_rate;
        err_scaled = {err_mag, {tthcb_pkg::GAIN_SHIFT{1'b0}}};
        glide_prod = rate_abs * cfg.glide_gain;
        stop_prod  = rate_abs * cfg.stop_gain;
        glide_hit  = {8'd0, err_scaled} <= glide_prod;
        stop_hit   = {8'd0, err_scaled} <= stop_prod;

        run_time      = item.now_ms - start_time_reg;
        brake_elapsed = item.now_ms - brake_since_reg;
        small_err  = mag16(first_error_reg) <= tthcb_pkg::SMALL_ERR_MAX;
        sign_flip  = err[15] != first_error_reg[15];
        timed_out  = (cfg.limit_ms != 32'd0) && (run_time >= cfg.limit_ms);
        early_done = small_err || sign_flip || timed_out;
        brake_end  = (brake_elapsed > {16'd0, cfg.brake_hold_ms})
                     || (rate_abs <= tthcb_pkg::SLOW_RATE_MAX);

        mode_glide = (glide_hit && mode_reg == tthcb_pkg::MODE_FULL)
                     ? tthcb_pkg::MODE_COAST : mode_reg;
        mode_stop  = (stop_hit && mode_glide != tthcb_pkg::MODE_BRAKE)
                     ? tthcb_pkg::MODE_BRAKE : mode_glide;

        goal_next        = goal_reg;
        first_error_next = first_error_reg;
        mode_next        = mode_reg;
        spin_neg_next    = spin_neg_reg;
        braking_next     = braking_reg;
        brake_since_next = brake_since_reg;
        start_time_next  = start_time_reg;
        kind             = tthcb_pkg::KIND_DONE;
        power            = 15'd0;
        spin_out         = spin_neg_reg;

        if (item.action == tthcb_pkg::ACT_START)
        begin
            goal_next        = goal_start;
            first_error_next = err_start;
            spin_neg_next    = err_start[15];
            mode_next        = tthcb_pkg::MODE_FULL;
            braking_next     = 1'b0;
            start_time_next  = item.now_ms;
            kind             = tthcb_pkg::KIND_STARTED;
        end
        else if (!early_done)
        begin
            mode_next = mode_stop;
            case (mode_stop)
                tthcb_pkg::MODE_COAST:
                begin
                    kind  = tthcb_pkg::KIND_DRIVE;
                    power = cfg.glide_power;
                end
                tthcb_pkg::MODE_BRAKE:
                begin
                    kind = tthcb_pkg::KIND_BRAKE;
                    if (!braking_reg)
                    begin
                        braking_next     = 1'b1;
                        brake_since_next = item.now_ms;
                    end
                    else if (brake_end)
                    begin
                        braking_next = 1'b0;
                        kind         = tthcb_pkg::KIND_DONE;
                    end
                end
                default:
                begin
                    kind  = tthcb_pkg::KIND_DRIVE;
                    power = cfg.full_power;
                end
            endcase
        end

        drive              = spin_out ? 16'(-{1'b0, power}) : {1'b0, power};
        result.kind        = kind;
        result.front_left  = drive;
        result.front_right = 16'(-drive);
        result.back_left   = 16'(-drive);
        result.back_right  = drive;
    end

    // hold state unless the item moves on to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg        <= '0;
            first_error_reg <= '0;
            mode_reg        <= tthcb_pkg::MODE_FULL;
            spin_neg_reg    <= 1'b0;
            braking_reg     <= 1'b0;
            brake_since_reg <= '0;
            start_time_reg  <= '0;
        end
        else if (advance)
        begin
            goal_reg        <= goal_next;
            first_error_reg <= first_error_next;
            mode_reg        <= mode_next;
            spin_neg_reg    <= spin_neg_next;
            braking_reg     <= braking_next;
            brake_since_reg <= brake_since_next;
            start_time_reg  <= start_time_next;
        end
    end

endmodule

[sv/turn_to_heading_coast_brake.sv]
// Pipeline: an input transfer loads the input register; the result register loads
// the computed result once it is free, and the result transfer follows from it.
// Throughput: one item per cycle while results are taken; an item sits in the input
// register while the result register may still hold the previous result.
// Reset (rst_n low, asynchronous): both pipeline registers empty, segment state
// cleared to goal zero and full power mode, config registers at their defaults.
module turn_to_heading_coast_brake (
    input  logic                  clk,
    input  logic                  rst_n,
    tthcb_item_if.sink            items,
    tthcb_result_if.source        results,
    tthcb_cfg_if.sink             cfg
);

    tthcb_pkg::cfg_t    cfg_val;
    tthcb_pkg::item_t   item_in;
    tthcb_pkg::item_t   item_reg;
    logic               item_valid_reg, item_valid_next;
    tthcb_pkg::result_t result_calc;
    tthcb_pkg::result_t result_reg;
    logic               result_valid_reg, result_valid_next;
    logic               out_free;
    logic               advance;

    assign cfg.ready = 1'b1;

    tthcb_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_val)
    );

    assign item_in.action    = items.action;
    assign item_in.heading   = items.heading;
    assign item_in.bearing   = items.bearing;
    assign item_in.turn_rate = items.turn_rate;
    assign item_in.now_ms    = items.now_ms;

    assign out_free    = !result_valid_reg || results.ready;
    assign advance     = item_valid_reg && out_free;
    assign items.ready = !item_valid_reg || out_free;

    always_comb
    begin
        item_valid_next   = items.ready ? items.valid : item_valid_reg;
        result_valid_next = out_free ? item_valid_reg : result_valid_reg;
    end

    tthcb_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_val),
        .result  (result_calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            item_reg <= item_in;
        end
        if (advance)
        begin
            result_reg <= result_calc;
        end
    end

    assign results.valid       = result_valid_reg;
    assign results.kind        = result_reg.kind;
    assign results.front_left  = result_reg.front_left;
    assign results.front_right = result_reg.front_right;
    assign results.back_left   = result_reg.back_left;
    assign results.back_right  = result_reg.back_right;

endmodule

[sv/tthcb_checker.sv]
module tthcb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic [1:0]         kind,
    input logic signed [15:0] front_left,
    input logic signed [15:0] front_right,
    input logic signed [15:0] back_left,
    input logic signed [15:0] back_right
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(kind) && $stable(front_left)
            && $stable(front_right) && $stable(back_left) && $stable(back_right))
        else $error("result changed while stalled");

    a_idle_power: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind != tthcb_pkg::KIND_DRIVE |->
            front_left == 16'sd0 && front_right == 16'sd0
            && back_left == 16'sd0 && back_right == 16'sd0)
        else $error("power on a non-drive result");

    a_spin_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == tthcb_pkg::KIND_DRIVE |->
            front_right == 16'(-front_left) && back_left == front_right
            && back_right == front_left && front_left != 16'sh8000)
        else $error("wheel powers do not form a turn in place");

endmodule

bind turn_to_heading_coast_brake tthcb_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (results.valid),
    .res_ready   (results.ready),
    .kind        (results.kind),
    .front_left  (results.front_left),
    .front_right (results.front_right),
    .back_left   (results.back_left),
    .back_right  (results.back_right)
);

[tb/sv/testbench.sv]
module testbench;

    localparam int MAX_GAP        = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 10;

    // no register lives at this index; writes to it must be ignored
    localparam logic [tthcb_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 4'd15;

    typedef enum {REGS_MIN, REGS_MAX, REGS_TYPICAL} regs_flavor_t;

    logic clk;
    logic rst_n;

    tthcb_item_if   items();
    tthcb_result_if results();
    tthcb_cfg_if    cfg();

    turn_to_heading_coast_brake dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cfg     (cfg)
    );

    // controller registers and segment state as the block should hold them
    tthcb_pkg::cfg_t    regs;
    logic signed [15:0] goal_q;
    logic signed [15:0] first_err_q;
    logic [1:0]         mode_q;
    logic               spin_neg_q;
    logic               braking_q;
    logic [31:0]        brake_since_q;
    logic [31:0]        start_q;

    tthcb_pkg::result_t expected_cmds[$];
    int          mismatches;
    int          items_sent;
    int          gap_left;
    bit          gaps_on;
    bit          sink_hold_req;
    logic [31:0] ms_clock;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int abs16(logic signed [15:0] v);
        return (v < 0) ? -int'(v) : int'(v);
    endfunction

    // motor command for one item; advances the segment state
    function automatic tthcb_pkg::result_t controller_step(tthcb_pkg::item_t it);
        logic signed [15:0] lo_goal;
        logic signed [15:0] hi_goal;
        logic signed [15:0] err;
        logic signed [15:0] pwr;
        logic signed [15:0] drive;
        logic signed [19:0] rate;
        longint             err_scaled;
        longint             rate_abs;
        tthcb_pkg::result_t r;

        r = '0;
        if (it.action == tthcb_pkg::ACT_START)
        begin
            lo_goal = it.bearing - $signed({1'b0, regs.drop_margin});
            hi_goal = it.bearing + $signed({1'b0, regs.drop_margin});
            if (abs16(lo_goal - it.heading) < abs16(hi_goal - it.heading))
                goal_q = lo_goal + regs.heading_offset;
            else
                goal_q = hi_goal + regs.heading_offset;
            first_err_q = goal_q - it.heading;
            spin_neg_q  = first_err_q[15];
            mode_q      = tthcb_pkg::MODE_FULL;
            braking_q   = 1'b0;
            start_q     = it.now_ms;
            r.kind      = tthcb_pkg::KIND_STARTED;
            return r;
        end

        err        = goal_q - it.heading;
        rate       = it.turn_rate;
        err_scaled = longint'(abs16(err)) * (longint'(1) << tthcb_pkg::GAIN_SHIFT);
        rate_abs   = (rate < 0) ? -longint'(rate) : longint'(rate);

        // small original error, sign flip, timeout: finish, state untouched
        if (abs16(first_err_q) <= int'(tthcb_pkg::SMALL_ERR_MAX) ||
            err[15] != first_err_q[15] ||
            (regs.limit_ms != 0 && (it.now_ms - start_q) >= regs.limit_ms))
        begin
            r.kind = tthcb_pkg::KIND_DONE;
            return r;
        end

        if (err_scaled <= rate_abs * regs.glide_gain && mode_q == tthcb_pkg::MODE_FULL)
            mode_q = tthcb_pkg::MODE_COAST;
        if (err_scaled <= rate_abs * regs.stop_gain && mode_q != tthcb_pkg::MODE_BRAKE)
            mode_q = tthcb_pkg::MODE_BRAKE;

        if (mode_q == tthcb_pkg::MODE_BRAKE)
        begin
            r.kind = tthcb_pkg::KIND_BRAKE;
            if (!braking_q)
            begin
                braking_q     = 1'b1;
                brake_since_q = it.now_ms;
            end
            else if ((it.now_ms - brake_since_q) > regs.brake_hold_ms ||
                     rate_abs <= tthcb_pkg::SLOW_RATE_MAX)
            begin
                braking_q = 1'b0;
                r.kind    = tthcb_pkg::KIND_DONE;
            end
            return r;
        end

        pwr           = (mode_q == tthcb_pkg::MODE_COAST) ? $signed({1'b0, regs.glide_power})
                                                          : $signed({1'b0, regs.full_power});
        drive         = spin_neg_q ? -pwr : pwr;
        r.kind        = tthcb_pkg::KIND_DRIVE;
        r.front_left  = drive;
        r.front_right = -drive;
        r.back_left   = -drive;
        r.back_right  = drive;
        return r;
    endfunction

    function automatic tthcb_pkg::item_t mk_item(logic act, int heading, int bearing,
                                                 int rate, logic [31:0] now);
        tthcb_pkg::item_t r;

        r.action    = act;
        r.heading   = heading[15:0];
        r.bearing   = bearing[15:0];
        r.turn_rate = rate[19:0];
        r.now_ms    = now;
        return r;
    endfunction

    // random garbage above the register's width
    function automatic logic [31:0] with_junk(logic [31:0] value, int width);
        logic [31:0] mask;

        mask = (width >= 32) ? '1 : ((32'd1 << width) - 32'd1);
        return ($urandom() & ~mask) | (value & mask);
    endfunction

    task automatic send_item(tthcb_pkg::item_t it);
        int gap;

        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            items.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        items.valid     = 1'b1;
        items.action    = it.action;
        items.heading   = it.heading;
        items.bearing   = it.bearing;
        items.turn_rate = it.turn_rate;
        items.now_ms    = it.now_ms;
        do
            @(posedge clk);
        while (!items.ready);
        expected_cmds.push_back(controller_step(it));
        items_sent++;
    endtask

    task automatic write_reg(logic [tthcb_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = data;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            tthcb_pkg::REG_DROP_MARGIN:    regs.drop_margin    = data[14:0];
            tthcb_pkg::REG_HEADING_OFFSET: regs.heading_offset = data[15:0];
            tthcb_pkg::REG_FULL_POWER:     regs.full_power     = data[14:0];
            tthcb_pkg::REG_GLIDE_POWER:    regs.glide_power    = data[14:0];
            tthcb_pkg::REG_GLIDE_GAIN:     regs.glide_gain     = data[15:0];
            tthcb_pkg::REG_STOP_GAIN:      regs.stop_gain      = data[15:0];
            tthcb_pkg::REG_BRAKE_HOLD_MS:  regs.brake_hold_ms  = data[15:0];
            tthcb_pkg::REG_LIMIT_MS:       regs.limit_ms       = data;
            default: ;
        endcase
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // drop valid, wait for every command, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        items.valid = 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_random_regs(regs_flavor_t flavor);
        logic [31:0] v[8];

        case (flavor)
            REGS_MIN:
            begin
                v = '{32'd0, 32'h8000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
            end
            REGS_MAX:
            begin
                v = '{32'd32767, 32'd32767, 32'd32767, 32'd32767,
                      32'd65535, 32'd65535, 32'd65535, 32'hFFFF_FFFF};
            end
            default:
            begin
                v[0] = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 4000);
                v[1] = $urandom_range(0, 2000) - 1000;
                v[2] = $urandom();
                v[3] = $urandom();
                v[4] = $urandom_range(1024, 20000);
                v[5] = $urandom_range(64, 4096);
                v[6] = $urandom_range(0, 40);
                v[7] = $urandom_range(0, 1) ? 32'd0 : $urandom_range(20, 200);
            end
        endcase
        write_reg(tthcb_pkg::REG_DROP_MARGIN,    with_junk(v[0], 15));
        write_reg(tthcb_pkg::REG_HEADING_OFFSET, with_junk(v[1], 16));
        write_reg(tthcb_pkg::REG_FULL_POWER,     with_junk(v[2], 15));
        write_reg(tthcb_pkg::REG_GLIDE_POWER,    with_junk(v[3], 15));
        write_reg(tthcb_pkg::REG_GLIDE_GAIN,     with_junk(v[4], 16));
        write_reg(tthcb_pkg::REG_STOP_GAIN,      with_junk(v[5], 16));
        write_reg(tthcb_pkg::REG_BRAKE_HOLD_MS,  with_junk(v[6], 16));
        write_reg(tthcb_pkg::REG_LIMIT_MS,       v[7]);
    endtask

    // start, then ticks closing in on the goal and a couple past it
    task automatic run_segment();
        logic signed [15:0] start_heading;
        logic signed [15:0] target;
        int                 remain;
        int                 n;
        int                 left;
        int                 rate;

        start_heading = 16'($urandom());
        if ($urandom_range(0, 7) == 0)
            ms_clock = 32'hFFFF_FF00 + $urandom_range(0, 255);
        ms_clock += $urandom_range(1, 20);
        send_item(mk_item(tthcb_pkg::ACT_START, int'(start_heading), $urandom(),
                          $urandom_range(0, 1000), ms_clock));
        target = goal_q;
        remain = int'(first_err_q);
        n      = $urandom_range(3, 14);
        for (int k = 1; k <= n + 2; k++)
        begin
            left = (remain * (n - k)) / n;
            if ($urandom_range(0, 3) == 0)
                rate = $urandom_range(0, 60);
            else
                rate = ((left < 0 ? -left : left) + $urandom_range(0, 4000)) *
                       $urandom_range(1, 4);
            if ($urandom_range(0, 1))
                rate = -rate;
            ms_clock += $urandom_range(1, 12);
            send_item(mk_item(tthcb_pkg::ACT_TICK,
                              int'(target) - left + $urandom_range(0, 64) - 32,
                              $urandom(), rate, ms_clock));
        end
    endtask

    task automatic test_before_start();
        // defaults: goal zero, no drop margin, so everything finishes at once
        send_item(mk_item(tthcb_pkg::ACT_TICK, 12345, 0, 524287, 32'd0));
        send_item(mk_item(tthcb_pkg::ACT_START, -32768, 32767, -524288, 32'hFFFF_FFFF));
        send_item(mk_item(tthcb_pkg::ACT_TICK, 0, -32768, 0, 32'd3));
    endtask

    task automatic test_extremes();
        drain();
        write_reg(tthcb_pkg::REG_DROP_MARGIN,    32'hFFFF_FFFF);
        write_reg(tthcb_pkg::REG_HEADING_OFFSET, 32'h0000_8000);
        write_reg(tthcb_pkg::REG_FULL_POWER,     32'h0000_7FFF);
        write_reg(tthcb_pkg::REG_GLIDE_POWER,    32'hFFFF_7FFF);
        write_reg(tthcb_pkg::REG_GLIDE_GAIN,     32'h0000_FFFF);
        write_reg(tthcb_pkg::REG_STOP_GAIN,      32'hFFFF_FFFF);
        write_reg(tthcb_pkg::REG_BRAKE_HOLD_MS,  32'h0000_FFFF);
        write_reg(tthcb_pkg::REG_LIMIT_MS,       32'hFFFF_FFFF);
        write_reg(REG_UNUSED,                    32'hDEAD_BEEF);
        send_item(mk_item(tthcb_pkg::ACT_START, 16384, -32768, 0, 32'd5));
        send_item(mk_item(tthcb_pkg::ACT_TICK, 16384, 32767, 524287, 32'd6));
        send_item(mk_item(tthcb_pkg::ACT_TICK, 16384, 0, -524288, 32'd7));
        // elapsed time wraps to all ones: equals the limit
        send_item(mk_item(tthcb_pkg::ACT_TICK, 16384, 0, -524288, 32'd4));
    endtask

    task automatic test_turn_phases();
        drain();
        write_reg(tthcb_pkg::REG_DROP_MARGIN,    32'd1000);
        write_reg(tthcb_pkg::REG_HEADING_OFFSET, 32'd100);
        write_reg(tthcb_pkg::REG_FULL_POWER,     32'd20000);
        write_reg(tthcb_pkg::REG_GLIDE_POWER,    32'd5000);
        write_reg(tthcb_pkg::REG_GLIDE_GAIN,     32'd4096);
        write_reg(tthcb_pkg::REG_STOP_GAIN,      32'd1024);
        write_reg(tthcb_pkg::REG_BRAKE_HOLD_MS,  32'd10);
        write_reg(tthcb_pkg::REG_LIMIT_MS,       32'd100);
        // positive spin: full power, coast, brake, hold expiry, slow rate
        send_item(mk_item(tthcb_pkg::ACT_START, 0, 10000, 0, 32'd1000));
        send_item(mk_item(tthcb_pkg::ACT_TICK, 0, 0, 100, 32'd1005));
        send_item(mk_item(tthcb_pkg::ACT_TICK, 5000, 0, 5000, 32'd1010));
        send_item(mk_item(tthcb_pkg::ACT_TICK, 8000, 0, 5000, 32'd1015));
        send_item(mk_item(tthcb_pkg::ACT_TICK, 8500, 0, 3000, 32'd1020));
        send_item(mk_item(tthcb_pkg::ACT_TICK, 8600, 0, 3000, 32'd1030));
        send_item(mk_item(tthcb_pkg::ACT_TICK, 8600, 0, 30, 32'd1031));
        send_item(mk_item(tthcb_pkg::ACT_TICK, 8700, 0, 40, 32'd1032));
        // overshoot flips the sign, then the timeout from start
        send_item(mk_item(tthcb_pkg::ACT_TICK, 9200, 0, 3000, 32'd1033));
        send_item(mk_item(tthcb_pkg::ACT_TICK, 8000, 0, 3000, 32'd1100));
        // negative spin
        send_item(mk_item(tthcb_pkg::ACT_START, 0, -10000, 0, 32'd2000));
        send_item(mk_item(tthcb_pkg::ACT_TICK, 0, 0, -100, 32'd2001));
        // goal already within a few degrees
        send_item(mk_item(tthcb_pkg::ACT_START, 500, 0, 0, 32'd3000));
        send_item(mk_item(tthcb_pkg::ACT_TICK, 500, 0, 0, 32'd3001));
    endtask

    task automatic test_random_segments();
        int target_count;

        for (int phase = 0; phase < 6; phase++)
        begin
            drain();
            case (phase)
                0:       set_random_regs(REGS_MIN);
                1:       set_random_regs(REGS_MAX);
                default: set_random_regs(REGS_TYPICAL);
            endcase
            gaps_on      = (phase != 3);
            target_count = items_sent + 105;
            while (items_sent < target_count)
            begin
                if ($urandom_range(0, 6) == 0)
                    send_item(mk_item(1'($urandom_range(0, 1)), $urandom(), $urandom(),
                                      $urandom(), $urandom()));
                else
                    run_segment();
            end
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        drain();
        set_random_regs(REGS_TYPICAL);
        gaps_on       = 1'b0;
        sink_hold_req = 1'b1;
        run_segment();
        run_segment();
        gaps_on = 1'b1;
    endtask

    // result ready: per-transfer stall, plus one long hold on request
    initial
    begin : result_ready_ctl
        results.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                results.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (gap_left > 0)
            begin
                results.ready = 1'b0;
                gap_left--;
            end
            else
            begin
                results.ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        tthcb_pkg::result_t want;

        if (rst_n && results.valid && results.ready)
        begin
            gap_left = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            if (expected_cmds.size() == 0)
            begin
                $error("unexpected transfer: kind %0d with no command pending", results.kind);
                mismatches++;
            end
            else
            begin
                want = expected_cmds.pop_front();
                if (results.kind !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, results.kind);
                    mismatches++;
                end
                if (results.front_left !== want.front_left)
                begin
                    $error("front_left: expected %0d, actual %0d",
                           want.front_left, results.front_left);
                    mismatches++;
                end
                if (results.front_right !== want.front_right)
                begin
                    $error("front_right: expected %0d, actual %0d",
                           want.front_right, results.front_right);
                    mismatches++;
                end
                if (results.back_left !== want.back_left)
                begin
                    $error("back_left: expected %0d, actual %0d",
                           want.back_left, results.back_left);
                    mismatches++;
                end
                if (results.back_right !== want.back_right)
                begin
                    $error("back_right: expected %0d, actual %0d",
                           want.back_right, results.back_right);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;

        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (items.valid && items.ready) || (results.valid && results.ready) ||
                (cfg.valid && cfg.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        items.valid     = 1'b0;
        items.action    = tthcb_pkg::ACT_START;
        items.heading   = '0;
        items.bearing   = '0;
        items.turn_rate = '0;
        items.now_ms    = '0;
        cfg.valid       = 1'b0;
        cfg.index       = tthcb_pkg::REG_DROP_MARGIN;
        cfg.data        = '0;
        mismatches      = 0;
        items_sent      = 0;
        gap_left        = 0;
        gaps_on         = 1'b1;
        sink_hold_req   = 1'b0;
        ms_clock        = '0;

        regs            = '0;
        regs.full_power = tthcb_pkg::FULL_POWER_RST;
        goal_q          = '0;
        first_err_q     = '0;
        mode_q          = tthcb_pkg::MODE_FULL;
        spin_neg_q      = 1'b0;
        braking_q       = 1'b0;
        brake_since_q   = '0;
        start_q         = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_before_start();
        test_extremes();
        test_turn_phases();
        test_random_segments();
        test_backpressure();

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_cmds.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
